// ----- rtl/core/grid_move_transition_engine_macros.svh -----
// assertion macros for the grid move transition engine checker
`ifndef GRID_MOVE_TRANSITION_ENGINE_MACROS_SVH
`define GRID_MOVE_TRANSITION_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define GMTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmte assertion failed");

// next-cycle implication, disabled during reset
`define GMTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmte assertion failed");

`endif

// ----- rtl/core/gmte_pkg.sv -----
// shared types and constants of the grid move transition engine
package gmte_pkg;

  localparam int MAX_ROWS     = 256;
  localparam int MAX_COLS     = 256;
  localparam int ACTION_COUNT = 4;
  localparam int MAP_DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int DIM_W        = 9;
  localparam int COORD_W      = 8;
  localparam int IDX_W        = 16;
  localparam int TOT_W        = IDX_W + 1;
  localparam int REW_W        = 16;
  localparam int DIVCNT_W     = $clog2(IDX_W);

  typedef enum logic [1:0] {
    OP_RECT  = 2'd0,
    OP_TERM  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    CFG_ROWS    = 2'd0,
    CFG_COLS    = 2'd1,
    CFG_MOVE    = 2'd2,
    CFG_ARRIVAL = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_src;
    logic cand_load;
    logic fill_init;
    logic fill_step;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic rect_empty;
    logic fill_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/grid_move_transition_engine.sv -----
// top level of the grid move transition engine
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   op, rect_top/left/bottom/right, cell_index, move_dir
//  out      output     out_valid / out_stall next_cell, reward
//  cfg      input      cfg_valid / cfg_ready index, data
//
// query: the remainder divider (one bit a cycle), then the candidate, lookup and response states produce the result
// obstacle rectangle: a setup state, then a fill state that marks each cell in turn through the single map write port
// terminal cell: setup and fill states, setup only when outside the grid; unused op: returns straight to idle
// after reset a clearing pass wipes all 65536 cells of both maps with in_stall held high
// a stalled result sits in the output register; the next transaction waits only for that slot
module grid_move_transition_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_rect_top,
  input  logic [7:0]         in_rect_left,
  input  logic [7:0]         in_rect_bottom,
  input  logic [7:0]         in_rect_right,
  input  logic [15:0]        in_cell_index,
  input  logic [1:0]         in_move_dir,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_next_cell,
  output logic signed [15:0] out_reward
);
  import gmte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gmte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  gmte_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_op          (in_op),
    .in_rect_top    (in_rect_top),
    .in_rect_left   (in_rect_left),
    .in_rect_bottom (in_rect_bottom),
    .in_rect_right  (in_rect_right),
    .in_cell_index  (in_cell_index),
    .in_move_dir    (in_move_dir),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_cell  (out_next_cell),
    .out_reward     (out_reward)
  );

endmodule

// ----- rtl/core/gmte_ram.sv -----
// generic single-write, single-read ram with registered read data
module gmte_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gmte_ctrl.sv -----
// controller state machine of the grid move transition engine
module gmte_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_stall,
  output gmte_pkg::cmd_t cmd,
  input  gmte_pkg::sts_t sts
);
  import gmte_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SETUP = 8'b0000_0100,
    ST_FILL  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_CAND  = 8'b0010_0000,
    ST_LOOK  = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (op_t'(in_op)) inside
            OP_RECT, OP_TERM: state_nxt = ST_SETUP;
            OP_QUERY:         state_nxt = ST_DIV;
            default:          state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP: begin
        cmd.fill_init = 1'b1;
        state_nxt     = sts.rect_empty ? ST_IDLE : ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.rd_src   = 1'b1;
        if (sts.div_done) state_nxt = ST_CAND;
      end
      ST_CAND: begin
        cmd.cand_load = 1'b1;
        state_nxt     = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ----- rtl/core/gmte_dp.sv -----
// datapath: config registers, cell maps, remainder divider, fill walker, result register
module gmte_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gmte_pkg::cmd_t       cmd,
  output gmte_pkg::sts_t       sts,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [1:0]           in_op,
  input  logic [7:0]           in_rect_top,
  input  logic [7:0]           in_rect_left,
  input  logic [7:0]           in_rect_bottom,
  input  logic [7:0]           in_rect_right,
  input  logic [15:0]          in_cell_index,
  input  logic [1:0]           in_move_dir,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_next_cell,
  output logic signed [15:0]   out_reward
);
  import gmte_pkg::*;

  // configuration
  logic [DIM_W-1:0]        rows_cfg_r, cols_cfg_r;
  logic signed [REW_W-1:0] move_rew_r, arr_rew_r;
  logic [DIM_W-1:0]        rows_eff, cols_eff;
  logic [COORD_W-1:0]      lim_row, lim_col;
  logic [TOT_W-1:0]        total_r;

  // transaction fields
  op_t                op_r;
  logic [COORD_W-1:0] top_r, left_r, bottom_r, right_r;
  logic [IDX_W-1:0]   src_r;
  dir_t               dir_r;

  // remainder divider
  logic [COORD_W-1:0]  rem_r;
  logic [IDX_W-1:0]    quo_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic [DIM_W-1:0]    trial;

  // query
  logic [TOT_W-1:0] src_w, cols_w;
  logic             cand_ok;
  logic [IDX_W-1:0] cand;
  logic [IDX_W-1:0] cand_r;
  logic             cand_ok_r, src_term_r, off_grid_r;
  logic             moved;
  logic [IDX_W-1:0] next_cell;
  logic signed [REW_W-1:0] reward;

  // fill walker
  logic [IDX_W-1:0]   base_r;
  logic [COORD_W-1:0] r_r, c_r;
  logic [COORD_W-1:0] r_hi, c_hi, r_end, c_end;
  logic [IDX_W-1:0]   fill_addr;
  logic [MAP_AW-1:0]  clr_r;

  // maps
  logic              obs_we, term_we, map_wdata;
  logic [MAP_AW-1:0] waddr, raddr;
  logic              obs_rd, term_rd;

  logic              out_valid_r;
  logic [IDX_W-1:0]  out_cell_r;
  logic signed [REW_W-1:0] out_rew_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= DIM_W'(MAX_ROWS);
      cols_cfg_r <= DIM_W'(MAX_COLS);
      move_rew_r <= -16'sd256;
      arr_rew_r  <= 16'sd25600;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS:    rows_cfg_r <= cfg_data[DIM_W-1:0];
        CFG_COLS:    cols_cfg_r <= cfg_data[DIM_W-1:0];
        CFG_MOVE:    move_rew_r <= cfg_data;
        CFG_ARRIVAL: arr_rew_r  <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg_r == '0)                      rows_eff = DIM_W'(1);
    else if (rows_cfg_r > DIM_W'(MAX_ROWS))    rows_eff = DIM_W'(MAX_ROWS);
    else                                       rows_eff = rows_cfg_r;
    if (cols_cfg_r == '0)                      cols_eff = DIM_W'(1);
    else if (cols_cfg_r > DIM_W'(MAX_COLS))    cols_eff = DIM_W'(MAX_COLS);
    else                                       cols_eff = cols_cfg_r;
  end

  assign lim_row = COORD_W'(rows_eff - DIM_W'(1));
  assign lim_col = COORD_W'(cols_eff - DIM_W'(1));

  always_ff @(posedge clk) begin
    total_r <= TOT_W'(rows_eff * cols_eff);
  end

  // transaction capture and remainder divider
  assign trial = {rem_r, quo_r[IDX_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_op);
      top_r    <= in_rect_top;
      left_r   <= in_rect_left;
      bottom_r <= in_rect_bottom;
      right_r  <= in_rect_right;
      src_r    <= in_cell_index;
      dir_r    <= dir_t'(in_move_dir);
      quo_r    <= in_cell_index;
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      rem_r <= (trial >= cols_eff) ? COORD_W'(trial - cols_eff) : trial[COORD_W-1:0];
      quo_r <= {quo_r[IDX_W-2:0], 1'b0};
      cnt_r <= cnt_r + DIVCNT_W'(1);
    end
  end

  // neighbour candidate
  assign src_w  = {1'b0, src_r};
  assign cols_w = TOT_W'(cols_eff);

  always_comb begin
    unique case (dir_r)
      DIR_UP: begin
        cand_ok = (src_w >= cols_w);
        cand    = IDX_W'(src_w - cols_w);
      end
      DIR_DOWN: begin
        cand_ok = ((src_w + cols_w) < total_r);
        cand    = IDX_W'(src_w + cols_w);
      end
      DIR_LEFT: begin
        cand_ok = (rem_r != '0);
        cand    = src_r - IDX_W'(1);
      end
      DIR_RIGHT: begin
        cand_ok = ((DIM_W'(rem_r) + DIM_W'(1)) < cols_eff);
        cand    = src_r + IDX_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand_r     <= cand;
      cand_ok_r  <= cand_ok;
      src_term_r <= term_rd;
      off_grid_r <= (src_w >= total_r);
    end
  end

  // result
  assign moved     = cand_ok_r && !obs_rd;
  assign next_cell = moved ? cand_r : src_r;

  always_comb begin
    if (off_grid_r || src_term_r) reward = '0;
    else if (moved && term_rd)    reward = arr_rew_r;
    else                          reward = move_rew_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r <= (off_grid_r || src_term_r) ? src_r : next_cell;
      out_rew_r  <= reward;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_next_cell = out_cell_r;
  assign out_reward    = out_rew_r;

  // rectangle and terminal marking
  assign r_hi  = (op_r == OP_RECT) ? bottom_r : top_r;
  assign c_hi  = (op_r == OP_RECT) ? right_r  : left_r;
  assign r_end = (r_hi < lim_row) ? r_hi : lim_row;
  assign c_end = (c_hi < lim_col) ? c_hi : lim_col;

  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      base_r <= IDX_W'(top_r * cols_eff);
      r_r    <= top_r;
      c_r    <= left_r;
    end else if (cmd.fill_step) begin
      if (c_r == c_end) begin
        c_r    <= left_r;
        r_r    <= r_r + COORD_W'(1);
        base_r <= base_r + IDX_W'(cols_eff);
      end else begin
        c_r <= c_r + COORD_W'(1);
      end
    end
  end

  assign fill_addr = base_r + IDX_W'(c_r);

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + MAP_AW'(1);
    end
  end

  assign obs_we    = cmd.clr_step || (cmd.fill_step && op_r == OP_RECT);
  assign term_we   = cmd.clr_step || (cmd.fill_step && op_r == OP_TERM);
  assign map_wdata = !cmd.clr_step;
  assign waddr     = cmd.clr_step ? clr_r : MAP_AW'(fill_addr);
  assign raddr     = cmd.rd_src ? MAP_AW'(src_r) : MAP_AW'(cand_r);

  gmte_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_obs_map (
    .clk   (clk),
    .we    (obs_we),
    .waddr (waddr),
    .wdata (map_wdata),
    .raddr (raddr),
    .rdata (obs_rd)
  );

  gmte_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_term_map (
    .clk   (clk),
    .we    (term_we),
    .waddr (waddr),
    .wdata (map_wdata),
    .raddr (raddr),
    .rdata (term_rd)
  );

  always_comb begin
    sts.div_done   = (cnt_r == DIVCNT_W'(IDX_W - 1));
    sts.rect_empty = (top_r > r_end) || (left_r > c_end);
    sts.fill_last  = (r_r == r_end) && (c_r == c_end);
    sts.clr_last   = (clr_r == '1);
    sts.out_free   = !out_valid_r || !out_stall;
  end

endmodule

// ----- rtl/core/gmte_checker.sv -----
// port-level checker for the grid move transition engine, with its bind
`include "grid_move_transition_engine_macros.svh"

module gmte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_op,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_next_cell,
  input logic signed [15:0] out_reward
);
  import gmte_pkg::*;

  `GMTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_next_cell) && $stable(out_reward))
  `GMTE_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && in_op == OP_QUERY, in_stall)
  `GMTE_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind grid_move_transition_engine gmte_checker u_gmte_checker (.*);

// ----- tb/sv/tb_grid_move_transition_engine.sv -----
// testbench for the grid move transition engine: directed and random traffic against a predictor
`timescale 1ns / 100ps

module tb_grid_move_transition_engine;
  import gmte_pkg::*;

  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 142;
  localparam int ROWS_SET [PHASES] = '{16, 0, 511, 1, 7, 256, 3, 40, -1, -1};
  localparam int COLS_SET [PHASES] = '{16, 300, 1, 1, 13, 256, 200, 2, -1, -1};

  typedef struct {
    op_t        op;
    logic [7:0] top;
    logic [7:0] left;
    logic [7:0] bottom;
    logic [7:0] right;
    logic [15:0] src_idx;
    dir_t       dir;
  } move_req_t;

  typedef struct {
    logic [15:0]        next_cell;
    logic signed [15:0] reward;
  } move_res_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_op;
  logic [7:0]         in_rect_top;
  logic [7:0]         in_rect_left;
  logic [7:0]         in_rect_bottom;
  logic [7:0]         in_rect_right;
  logic [15:0]        in_cell_index;
  logic [1:0]         in_move_dir;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_next_cell;
  logic signed [15:0] out_reward;

  // predictor state
  bit          wall_cells [MAP_DEPTH];
  bit          goal_cells [MAP_DEPTH];
  logic [8:0]  rows_setting;
  logic [8:0]  cols_setting;
  logic [15:0] plain_move_value;
  logic [15:0] arrive_value;
  move_res_t   expected_moves [$];
  move_res_t   oldest_move;
  int          quiet_work;
  int          hot_cell;

  int mismatch_count;
  int results_seen;
  int idle_cycles;
  int gap_odds;
  int sink_stall_odds;
  int rect_count;
  int term_count;
  int query_count;
  int unused_count;
  int stay_count;
  int goal_hits;
  int setting_count;

  grid_move_transition_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_rect_top    (in_rect_top),
    .in_rect_left   (in_rect_left),
    .in_rect_bottom (in_rect_bottom),
    .in_rect_right  (in_rect_right),
    .in_cell_index  (in_cell_index),
    .in_move_dir    (in_move_dir),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_cell  (out_next_cell),
    .out_reward     (out_reward)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int grid_span(input logic [8:0] raw, input int limit);
    if (raw == 9'd0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  function automatic void predict_transition(input move_req_t rq);
    int rows, cols, r, c, nr, nc, src, nxt, cells;
    move_res_t res;
    rows  = grid_span(rows_setting, MAX_ROWS);
    cols  = grid_span(cols_setting, MAX_COLS);
    cells = 0;
    case (rq.op)
      OP_RECT: begin
        for (r = int'(rq.top); r <= int'(rq.bottom) && r < rows; r++) begin
          for (c = int'(rq.left); c <= int'(rq.right) && c < cols; c++) begin
            wall_cells[r * cols + c] = 1'b1;
            hot_cell = r * cols + c;
            cells++;
          end
        end
        quiet_work += 2 + cells;
        rect_count++;
      end
      OP_TERM: begin
        if (int'(rq.top) < rows && int'(rq.left) < cols) begin
          goal_cells[int'(rq.top) * cols + int'(rq.left)] = 1'b1;
          hot_cell = int'(rq.top) * cols + int'(rq.left);
        end
        quiet_work += 3;
        term_count++;
      end
      OP_QUERY: begin
        src = int'(rq.src_idx);
        nxt = src;
        if (src >= rows * cols || goal_cells[src]) begin
          res.reward = '0;
        end else begin
          nr = src / cols;
          nc = src % cols;
          case (rq.dir)
            DIR_UP:   nr--;
            DIR_DOWN: nr++;
            DIR_LEFT: nc--;
            default:  nc++;
          endcase
          if (nr >= 0 && nr < rows && nc >= 0 && nc < cols && nr * cols + nc <= 16'hFFFF
              && !wall_cells[nr * cols + nc])
            nxt = nr * cols + nc;
          res.reward = goal_cells[nxt] ? arrive_value : plain_move_value;
          if (goal_cells[nxt]) goal_hits++;
        end
        if (nxt == src) stay_count++;
        res.next_cell = nxt[15:0];
        expected_moves.push_back(res);
        quiet_work = 0;
        query_count++;
      end
      default: begin
        quiet_work += 1;
        unused_count++;
      end
    endcase
  endfunction

  function automatic move_req_t make_req(input op_t op, input int top, input int left,
                                         input int bottom, input int right, input int src_idx,
                                         input dir_t dir);
    move_req_t rq;
    rq.op      = op;
    rq.top     = top[7:0];
    rq.left    = left[7:0];
    rq.bottom  = bottom[7:0];
    rq.right   = right[7:0];
    rq.src_idx = src_idx[15:0];
    rq.dir     = dir;
    return rq;
  endfunction

  function automatic move_req_t random_req(input int rows, input int cols);
    move_req_t rq;
    int pick, t, l, pick_idx;
    rq.op      = OP_QUERY;
    rq.top     = 8'($urandom);
    rq.left    = 8'($urandom);
    rq.bottom  = 8'($urandom);
    rq.right   = 8'($urandom);
    rq.src_idx = 16'($urandom);
    rq.dir     = dir_t'($urandom_range(0, 3));
    pick       = $urandom_range(0, 99);
    if (pick < 8) begin
      rq.op = OP_RECT;
      if (rows * cols > 1024 || $urandom_range(0, 9) != 0) begin
        t = $urandom_range(0, rows - 1);
        l = $urandom_range(0, cols - 1);
        rq.top    = t[7:0];
        rq.left   = l[7:0];
        t += $urandom_range(0, 2);
        l += $urandom_range(0, 2);
        rq.bottom = (t > 255) ? 8'd255 : t[7:0];
        rq.right  = (l > 255) ? 8'd255 : l[7:0];
        if ($urandom_range(0, 7) == 0) begin
          rq.top    = rq.bottom;
          rq.bottom = rq.left;
        end
      end
    end else if (pick < 14) begin
      rq.op = OP_TERM;
      if ($urandom_range(0, 4) != 0) begin
        t = $urandom_range(0, rows - 1);
        l = $urandom_range(0, cols - 1);
        rq.top  = t[7:0];
        rq.left = l[7:0];
      end
    end else if (pick < 17) begin
      rq.op = OP_NONE;
    end else if ($urandom_range(0, 9) < 7) begin
      pick_idx = $urandom_range(0, rows * cols - 1);
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 4))
          0: pick_idx = hot_cell;
          1: pick_idx = hot_cell + 1;
          2: pick_idx = hot_cell - 1;
          3: pick_idx = hot_cell + cols;
          default: pick_idx = hot_cell - cols;
        endcase
        if (pick_idx < 0) pick_idx = 0;
        if (pick_idx > 65535) pick_idx = 65535;
      end
      rq.src_idx = pick_idx[15:0];
    end
    return rq;
  endfunction

  task automatic send_request(input move_req_t rq);
    @(negedge clk);
    in_valid       = 1'b1;
    in_op          = rq.op;
    in_rect_top    = rq.top;
    in_rect_left   = rq.left;
    in_rect_bottom = rq.bottom;
    in_rect_right  = rq.right;
    in_cell_index  = rq.src_idx;
    in_move_dir    = rq.dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transition(rq);
  endtask

  task automatic hold_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait for every pending result, then let trailing fills finish
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (quiet_work + 40) @(posedge clk);
    quiet_work = 0;
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROWS: rows_setting     = value[8:0];
      CFG_COLS: cols_setting     = value[8:0];
      CFG_MOVE: plain_move_value = value;
      default:  arrive_value     = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_setting(input logic [15:0] rows, input logic [15:0] cols,
                              input logic [15:0] move_rw, input logic [15:0] arrive_rw);
    settle_block();
    write_register(CFG_ROWS, rows);
    write_register(CFG_COLS, cols);
    write_register(CFG_MOVE, move_rw);
    write_register(CFG_ARRIVAL, arrive_rw);
    setting_count++;
  endtask

  task automatic test_reset_state();
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 0, DIR_DOWN));
    send_request(make_req(OP_QUERY, 255, 255, 255, 255, 65535, DIR_DOWN));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 65535, DIR_RIGHT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 255, DIR_RIGHT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 256, DIR_LEFT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 257, DIR_LEFT));
    send_request(make_req(OP_NONE, 255, 255, 255, 255, 65535, DIR_RIGHT));
  endtask

  task automatic test_marking_rules();
    send_request(make_req(OP_TERM, 0, 1, 0, 0, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 0, DIR_RIGHT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1, DIR_DOWN));
    send_request(make_req(OP_RECT, 2, 0, 2, 0, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 256, DIR_DOWN));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 512, DIR_UP));
    // top below bottom marks nothing
    send_request(make_req(OP_RECT, 6, 0, 5, 255, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 1280, DIR_DOWN));
  endtask

  task automatic test_small_grid_extremes();
    load_setting(16'd3, 16'd5, 16'h8000, 16'h7FFF);
    send_request(make_req(OP_TERM, 200, 2, 0, 0, 0, DIR_UP));
    send_request(make_req(OP_TERM, 2, 4, 0, 0, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 13, DIR_RIGHT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 15, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 65535, DIR_LEFT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 0, DIR_RIGHT));
    // whole-field rectangle clipped to the grid
    send_request(make_req(OP_RECT, 0, 0, 255, 255, 0, DIR_UP));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 7, DIR_UP));
  endtask

  task automatic test_size_saturation();
    load_setting(16'd0, 16'h01FF, 16'hFF00, 16'd25600);
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 255, DIR_RIGHT));
    send_request(make_req(OP_QUERY, 0, 0, 0, 0, 256, DIR_UP));
  endtask

  task automatic test_random_traffic();
    logic [15:0] rewards [5];
    int raw_rows, raw_cols, rows, cols, p, i;
    rewards = '{16'hFF00, 16'h8000, 16'h7FFF, 16'h0000, 16'd25600};
    for (p = 0; p < PHASES; p++) begin
      raw_rows = (ROWS_SET[p] < 0) ? $urandom_range(0, 511) : ROWS_SET[p];
      raw_cols = (COLS_SET[p] < 0) ? $urandom_range(0, 511) : COLS_SET[p];
      gap_odds        = 0;
      sink_stall_odds = 0;
      load_setting({(p % 2 == 1) ? 7'($urandom) : 7'd0, raw_rows[8:0]},
                   {(p % 2 == 1) ? 7'($urandom) : 7'd0, raw_cols[8:0]},
                   (p % 3 == 2) ? 16'($urandom) : rewards[p % 5],
                   (p % 3 == 1) ? 16'($urandom) : rewards[(p + 2) % 5]);
      if (p != PHASES - 1) begin
        case (p % 3)
          0: gap_odds = 0;
          1: gap_odds = 8;
          default: gap_odds = 3;
        endcase
        case ((p + 1) % 3)
          0: sink_stall_odds = 0;
          1: sink_stall_odds = 12;
          default: sink_stall_odds = 4;
        endcase
      end
      rows = grid_span(rows_setting, MAX_ROWS);
      cols = grid_span(cols_setting, MAX_COLS);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
          hold_input($urandom_range(1, 16));
        if (p % 2 == 1 && i == ITEMS_PER_PHASE / 2)
          settle_block();
        send_request(random_req(rows, cols));
      end
    end
  endtask

  initial begin : sink_pacing
    int burst;
    out_stall = 1'b0;
    forever begin
      if (sink_stall_odds != 0 && $urandom_range(0, sink_stall_odds - 1) == 0) begin
        burst     = $urandom_range(1, 16);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_moves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: next_cell %0d reward %0d",
                   out_next_cell, out_reward);
      end else begin
        oldest_move = expected_moves.pop_front();
        if (out_next_cell !== oldest_move.next_cell || out_reward !== oldest_move.reward) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at result %0d: next_cell exp %0d got %0d, reward exp %0d got %0d",
                     results_seen, oldest_move.next_cell, out_next_cell,
                     oldest_move.reward, out_reward);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, expected_moves.size());
      $display("** grid_move_transition_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_ROWS;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_op            = OP_NONE;
    in_rect_top      = '0;
    in_rect_left     = '0;
    in_rect_bottom   = '0;
    in_rect_right    = '0;
    in_cell_index    = '0;
    in_move_dir      = DIR_UP;
    rows_setting     = 9'd256;
    cols_setting     = 9'd256;
    plain_move_value = 16'hFF00;
    arrive_value     = 16'd25600;
    quiet_work       = 0;
    hot_cell         = 0;
    idle_cycles      = 0;
    gap_odds         = 0;
    sink_stall_odds  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_marking_rules();
    test_small_grid_extremes();
    test_size_saturation();
    test_random_traffic();
    settle_block();

    $display("covered %0d obstacle fills, %0d terminal marks, %0d ignored ops, %0d queries",
             rect_count, term_count, unused_count, query_count);
    $display("queries: %0d stayed put, %0d reached a terminal, over %0d grid settings",
             stay_count, goal_hits, setting_count + 1);
    if (mismatch_count == 0)
      $display("** grid_move_transition_engine: PASSED **");
    else
      $display("** grid_move_transition_engine: FAILED **");
    $finish;
  end

endmodule
